// ===== src/cab_pkg.sv =====
// Shared types, constants and helpers for the clipped alpha-blend pixel writer.
// No dependencies; every other file in src imports this package.
package cab_pkg;

   // field widths
   localparam int COORD_W    = 16;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 24;
   localparam int OUT_ADDR_W = 16;
   localparam int CFG_W      = 9;
   localparam int DIM_W      = 13;   // holds the largest frame dimension parameter
   localparam int ADDR_W     = 18;   // y*w+x with w, h below 512
   localparam int IDX_MAX_W  = 24;   // largest store index width

   // default store size
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 9'd256;

   // opaque alpha, channel full scale
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   // front-to-back queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [CHAN_W-1:0]         src_red;
      logic [CHAN_W-1:0]         src_green;
      logic [CHAN_W-1:0]         src_blue;
      logic [CHAN_W-1:0]         src_alpha;
   } cab_req_type;

   typedef struct packed {
      logic                  written;
      logic [OUT_ADDR_W-1:0] pixel_address;
      logic [PIX_W-1:0]      pixel_value;
   } cab_rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      logic              clipped;
      logic              opaque;
      logic [ADDR_W-1:0] addr;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } cab_job_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_MULT,
      BK_DONE
   } cab_back_state_type;

   // floor(s/255) for s <= 255*255: (s + (s>>8) + 1) >> 8
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] s);
      logic [2*CHAN_W:0] t;
      t = {1'b0, s} + {9'b0, s[2*CHAN_W-1:CHAN_W]} + 17'd1;
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

// ===== src/clipped_alpha_blend_pixel_write.sv =====
// Top level of the clipped alpha-blend pixel writer: CSRs, front end, queue, back end.
// Depends on cab_pkg, cab_front, cab_fifo and cab_back.
//
//  channel  ports                                  direction  word
//  req      req_push, req_full, req_data           in         cab_req_type
//  rsp      rsp_pop, rsp_empty, rsp_data           out        cab_rsp_type
//  csr      csr_valid, csr_ready, csr_index, ...   in         9-bit frame size
//
// The front end takes one word per cycle into a four-entry queue, except while the
// queue is full or the store is being cleared. The back end runs each word through its
// sequencer: a blended pixel through pop, store read, multiply and write; an opaque or
// clipped one through pop and the write step only. After reset the store is cleared one
// pixel a cycle, all MAX_WIDTH*MAX_HEIGHT pixels (65536 by default), with req_full high.
// A result held in the output register stalls the back end, and so in turn the front end.
module clipped_alpha_blend_pixel_write #(
   parameter int MAX_WIDTH  = cab_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cab_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  cab_pkg::cab_req_type          req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output cab_pkg::cab_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cab_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cab_pkg::CFG_W-1:0]     csr_wdata
);
   import cab_pkg::*;

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic             clearing;
   logic             q_push, q_full, q_pop, q_empty;
   cab_job_type      q_in_job, q_out_job;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_DIM_RESET;
         frame_height_ff <= CFG_DIM_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   cab_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .clearing     (clearing),
      .q_push       (q_push),
      .q_job        (q_in_job),
      .q_full       (q_full)
   );

   cab_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_job),
      .empty     (q_empty)
   );

   cab_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (q_out_job),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // a clipped word reports zero address and pixel
   a_clipped_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.written) |->
         (rsp_data.pixel_address == '0 && rsp_data.pixel_value == '0))
      else $error("clipped word carries nonzero fields");

   // no work in flight while the store is being cleared
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (q_empty && rsp_empty && !q_pop))
      else $error("word in flight during store clear");

   // the back end only pops when the queue holds a word
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");
`endif

endmodule

// ===== src/cab_front.sv =====
// Front end: takes request words, clips them against the frame and forms the address.
// Depends on cab_pkg.
module cab_front #(
   parameter int MAX_WIDTH  = cab_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cab_pkg::MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  cab_pkg::cab_req_type        req_data,
   input  logic [cab_pkg::CFG_W-1:0]   frame_width,
   input  logic [cab_pkg::CFG_W-1:0]   frame_height,
   input  logic                        clearing,
   output logic                        q_push,
   output cab_pkg::cab_job_type        q_job,
   input  logic                        q_full
);
   import cab_pkg::*;

   localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAXH = DIM_W'(MAX_HEIGHT);

   logic        stage_valid_ff, stage_valid_in;
   cab_req_type stage_ff, stage_in;
   logic        accept;
   logic [CFG_W-1:0]   w_eff, h_eff;
   logic [COORD_W-2:0] x_mag, y_mag;
   logic               clipped;
   logic [ADDR_W-1:0]  row_base, addr;

   // input stage handshake
   always_comb begin
      req_full       = clearing | (stage_valid_ff & q_full);
      accept         = req_push & ~req_full;
      q_push         = stage_valid_ff & ~q_full;
      stage_valid_in = accept | (stage_valid_ff & ~q_push);
      stage_in       = accept ? req_data : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

   // clamp the configured size to the store
   always_comb begin
      w_eff = (DIM_W'(frame_width) > MAXW) ? MAXW[CFG_W-1:0] : frame_width;
      h_eff = (DIM_W'(frame_height) > MAXH) ? MAXH[CFG_W-1:0] : frame_height;
   end

   // clip and address
   always_comb begin
      x_mag    = stage_ff.pos_x[COORD_W-2:0];
      y_mag    = stage_ff.pos_y[COORD_W-2:0];
      clipped  = stage_ff.pos_x[COORD_W-1] | stage_ff.pos_y[COORD_W-1]
               | (x_mag >= (COORD_W-1)'(w_eff)) | (y_mag >= (COORD_W-1)'(h_eff));
      row_base = ADDR_W'(y_mag[CFG_W-1:0]) * ADDR_W'(w_eff);
      addr     = row_base + ADDR_W'(x_mag[CFG_W-1:0]);

      q_job.clipped = clipped;
      q_job.opaque  = (stage_ff.src_alpha == CHAN_MAX);
      q_job.addr    = clipped ? '0 : addr;
      q_job.red     = stage_ff.src_red;
      q_job.green   = stage_ff.src_green;
      q_job.blue    = stage_ff.src_blue;
      q_job.alpha   = stage_ff.src_alpha;
   end

endmodule

// ===== src/cab_fifo.sv =====
// Short queue of classified words between front and back end.
// Depends on cab_pkg.
module cab_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cab_pkg::cab_job_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output cab_pkg::cab_job_type  pop_data,
   output logic                  empty
);
   import cab_pkg::*;

   cab_job_type       entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   always_comb begin
      full     = (cnt_ff == QCNT_W'(QDEPTH));
      empty    = (cnt_ff == '0);
      do_push  = push & ~full;
      do_pop   = pop & ~empty;
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in   = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      pop_data = entry_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== src/cab_back.sv =====
// Back end: clears the store, then writes unclipped pixels singly, blending if not opaque.
// Holds the frame store and the result register. Depends on cab_pkg.
module cab_back #(
   parameter int MAX_WIDTH  = cab_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cab_pkg::MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  cab_pkg::cab_job_type  q_job,
   output logic                  q_pop,
   output logic                  clearing,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output cab_pkg::cab_rsp_type  rsp_data
);
   import cab_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   cab_back_state_type state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   cab_job_type        job_ff, job_in;
   logic [2*CHAN_W-1:0] sum_r_ff, sum_r_in, sum_g_ff, sum_g_in, sum_b_ff, sum_b_in;
   cab_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [PIX_W-1:0]   store_ff [DEPTH];
   logic [PIX_W-1:0]   rdata_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_widx, job_idx;
   logic [PIX_W-1:0]   mem_wdata, new_pix;
   logic [IDX_MAX_W-1:0] addr_ext;
   logic [CHAN_W-1:0]  inv_a;

   assign clearing  = (state_ff == BK_CLEAR);
   assign rsp_empty = ~rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // store index, inverse alpha and new pixel value of the current word
   always_comb begin
      addr_ext = IDX_MAX_W'(job_ff.addr);
      job_idx  = addr_ext[IDX_W-1:0];
      inv_a    = CHAN_MAX - job_ff.alpha;
      if (job_ff.opaque) begin
         new_pix = {job_ff.red, job_ff.green, job_ff.blue};
      end else begin
         new_pix = {div255(sum_r_ff), div255(sum_g_ff), div255(sum_b_ff)};
      end
   end

   // sequencer: next state, store write, result load
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      job_in       = job_ff;
      sum_r_in     = sum_r_ff;
      sum_g_in     = sum_g_ff;
      sum_b_in     = sum_b_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_pop;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_widx     = job_idx;
      mem_wdata    = new_pix;
      case (state_ff)
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_widx  = clr_ff;
            mem_wdata = '0;
            if (clr_ff == LAST_IDX) begin
               state_in = BK_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               state_in = (q_job.clipped || q_job.opaque) ? BK_DONE : BK_READ;
            end
         end
         BK_READ: begin
            // background pixel lands in rdata_ff at this edge
            state_in = BK_MULT;
         end
         BK_MULT: begin
            sum_r_in = (2*CHAN_W)'(job_ff.red) * (2*CHAN_W)'(job_ff.alpha)
                     + (2*CHAN_W)'(rdata_ff[23:16]) * (2*CHAN_W)'(inv_a);
            sum_g_in = (2*CHAN_W)'(job_ff.green) * (2*CHAN_W)'(job_ff.alpha)
                     + (2*CHAN_W)'(rdata_ff[15:8]) * (2*CHAN_W)'(inv_a);
            sum_b_in = (2*CHAN_W)'(job_ff.blue) * (2*CHAN_W)'(job_ff.alpha)
                     + (2*CHAN_W)'(rdata_ff[7:0]) * (2*CHAN_W)'(inv_a);
            state_in = BK_DONE;
         end
         BK_DONE: begin
            // wait for a free result slot
            if (!rsp_valid_ff || rsp_pop) begin
               mem_we       = ~job_ff.clipped;
               rsp_valid_in = 1'b1;
               if (job_ff.clipped) begin
                  rsp_in = '0;
               end else begin
                  rsp_in.written       = 1'b1;
                  rsp_in.pixel_address = job_ff.addr[OUT_ADDR_W-1:0];
                  rsp_in.pixel_value   = new_pix;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff   <= job_in;
      sum_r_ff <= sum_r_in;
      sum_g_ff <= sum_g_in;
      sum_b_ff <= sum_b_in;
      rsp_ff   <= rsp_in;
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_widx] <= mem_wdata;
      end
      rdata_ff <= store_ff[job_idx];
   end

endmodule
